[sv/csb_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and helpers for the counting semaphore bank.
// Used by every module of the block except csb_ram; depends on nothing.
package csb_pkg;

  localparam int unsigned DefaultNumSemaphores = 8;
  localparam int unsigned DefaultNumThreads    = 16;

  localparam int unsigned SemIdWidth    = 3;
  localparam int unsigned ThreadIdWidth = 4;
  localparam int unsigned CountWidth    = 9;
  localparam int unsigned InitWidth     = 8;

  localparam logic [InitWidth-1:0] InitCountReset = 8'd1;
  localparam logic signed [CountWidth-1:0] CountMax = 9'sd255;

  typedef enum logic {
    OP_WAIT   = 1'b0,
    OP_SIGNAL = 1'b1
  } op_e_t;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_RELEASED = 3'd2,
    ST_WOKE     = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_EXEC,
    BK_LINK,
    BK_HEAD,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    op_e_t                    op;
    logic [SemIdWidth-1:0]    sem_id;
    logic [ThreadIdWidth-1:0] thread_id;
  } req_t;

  // Reduces a narrow id modulo a bank size by repeated compare and subtract.
  function automatic logic [ThreadIdWidth-1:0] wrap_id(
    input logic [ThreadIdWidth-1:0] v,
    input int unsigned              m
  );
    logic [ThreadIdWidth-1:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (32'(r) >= m) begin
        r = r - ThreadIdWidth'(m);
      end
    end
    return r;
  endfunction

endpackage

[sv/csb_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
module csb_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/csb_front.sv]
`timescale 1ns / 1ps
// Front end: accepts request items, classifies the operation and holds them
// in a two-entry queue for the back end. Depends on csb_pkg.
module csb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tuser,
  output logic          req_valid,
  output csb_pkg::req_t req,
  input  logic          req_pop
);

  csb_pkg::req_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  csb_pkg::req_t in_req;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign pop       = req_pop && (cnt_r != 2'd0);
  assign req_valid = (cnt_r != 2'd0);
  assign req       = q_r[rd_ptr_r];

  always_comb begin
    in_req.op        = in_tuser ? csb_pkg::OP_SIGNAL : csb_pkg::OP_WAIT;
    in_req.sem_id    = in_tdata[2:0];
    in_req.thread_id = in_tdata[6:3];
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_req;
    end
  end

endmodule

[sv/csb_back.sv]
`timescale 1ns / 1ps
// Back end: read-modify-write of semaphore count and wait-queue links, plus
// the result register. Depends on csb_pkg and csb_ram.
module csb_back #(
  parameter int unsigned NUM_SEMAPHORES = csb_pkg::DefaultNumSemaphores,
  parameter int unsigned NUM_THREADS    = csb_pkg::DefaultNumThreads
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  input  logic          req_valid,
  input  csb_pkg::req_t req,
  output logic          req_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata,
  output logic [2:0]    out_tuser
);

  localparam int unsigned SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int unsigned TW = $clog2(NUM_THREADS);
  localparam logic signed [csb_pkg::CountWidth-1:0] QueueLimit =
    csb_pkg::CountWidth'(-$signed(NUM_THREADS));

  csb_pkg::back_state_t state_r, state_nxt;

  logic [csb_pkg::InitWidth-1:0] init_r;
  logic [NUM_SEMAPHORES-1:0]     cnt_vld_r;
  logic                          cvld_r;
  csb_pkg::op_e_t                op_r;
  logic [SW-1:0]                 sem_r;
  logic [TW-1:0]                 thr_r;
  csb_pkg::status_t              res_status_r;
  logic [TW-1:0]                 res_woken_r;
  logic signed [csb_pkg::CountWidth-1:0] res_count_r;

  logic                          out_valid_r;
  csb_pkg::status_t              out_status_r;
  logic [TW-1:0]                 out_woken_r;
  logic signed [csb_pkg::CountWidth-1:0] out_count_r;

  logic [SW-1:0] s_w;
  logic [TW-1:0] t_w;

  // RAM ports
  logic                                  cnt_we;
  logic signed [csb_pkg::CountWidth-1:0] cnt_wdata, cnt_rdata;
  logic          head_we, tail_we, next_we;
  logic [SW-1:0] head_waddr;
  logic [TW-1:0] head_wdata, head_rdata, tail_rdata;
  logic [TW-1:0] next_waddr, next_wdata, next_rdata;

  // Execution datapath
  logic signed [csb_pkg::CountWidth-1:0] c_cur, c_new;
  csb_pkg::status_t status_c;
  logic [TW-1:0]    woken_c;
  logic             to_link, to_head;
  logic             out_load;

  assign s_w = SW'(csb_pkg::wrap_id(4'(req.sem_id), NUM_SEMAPHORES));
  assign t_w = TW'(csb_pkg::wrap_id(req.thread_id, NUM_THREADS));

  csb_ram #(.WIDTH(csb_pkg::CountWidth), .DEPTH(NUM_SEMAPHORES)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(sem_r), .wdata(cnt_wdata),
    .raddr(s_w), .rdata(cnt_rdata)
  );
  csb_ram #(.WIDTH(TW), .DEPTH(NUM_SEMAPHORES)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(s_w), .rdata(head_rdata)
  );
  csb_ram #(.WIDTH(TW), .DEPTH(NUM_SEMAPHORES)) u_tail_ram (
    .clk(clk), .we(tail_we), .waddr(sem_r), .wdata(thr_r),
    .raddr(s_w), .rdata(tail_rdata)
  );
  csb_ram #(.WIDTH(TW), .DEPTH(NUM_THREADS)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(head_rdata), .rdata(next_rdata)
  );

  // Count update and result classification for the item in execution.
  always_comb begin
    c_cur    = cvld_r ? cnt_rdata : $signed({1'b0, init_r});
    c_new    = c_cur;
    status_c = csb_pkg::ST_OVERFLOW;
    woken_c  = '0;
    if (op_r == csb_pkg::OP_WAIT) begin
      if (c_cur > QueueLimit) begin
        c_new    = c_cur - 9'sd1;
        status_c = (c_new >= 9'sd0) ? csb_pkg::ST_GRANTED : csb_pkg::ST_BLOCKED;
      end
    end else begin
      if (c_cur >= csb_pkg::CountMax) begin
        c_new = csb_pkg::CountMax;
      end else if (c_cur < 9'sd0) begin
        c_new    = c_cur + 9'sd1;
        status_c = csb_pkg::ST_WOKE;
        woken_c  = head_rdata;
      end else begin
        c_new    = c_cur + 9'sd1;
        status_c = csb_pkg::ST_RELEASED;
      end
    end
    to_link = (status_c == csb_pkg::ST_BLOCKED) && (c_new < -9'sd1);
    to_head = (status_c == csb_pkg::ST_WOKE) && (c_new < 9'sd0);
  end

  assign out_load = (state_r == csb_pkg::BK_OUT) && (!out_valid_r || out_tready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csb_pkg::BK_IDLE: if (req_valid) state_nxt = csb_pkg::BK_EXEC;
      csb_pkg::BK_EXEC: begin
        if (to_link) begin
          state_nxt = csb_pkg::BK_LINK;
        end else if (to_head) begin
          state_nxt = csb_pkg::BK_HEAD;
        end else begin
          state_nxt = csb_pkg::BK_OUT;
        end
      end
      csb_pkg::BK_LINK: state_nxt = csb_pkg::BK_OUT;
      csb_pkg::BK_HEAD: state_nxt = csb_pkg::BK_OUT;
      csb_pkg::BK_OUT:  if (out_load) state_nxt = csb_pkg::BK_IDLE;
      default:          state_nxt = csb_pkg::BK_IDLE;
    endcase
  end

  // Memory strobes per state.
  always_comb begin
    req_pop    = 1'b0;
    cnt_we     = 1'b0;
    cnt_wdata  = c_new;
    head_we    = 1'b0;
    head_waddr = sem_r;
    head_wdata = thr_r;
    tail_we    = 1'b0;
    next_we    = 1'b0;
    next_waddr = thr_r;
    next_wdata = '0;
    unique case (state_r)
      csb_pkg::BK_IDLE: req_pop = req_valid;
      csb_pkg::BK_EXEC: begin
        cnt_we = 1'b1;
        if (status_c == csb_pkg::ST_BLOCKED) begin
          tail_we = 1'b1;
          next_we = 1'b1;
          if (c_new == -9'sd1) begin
            // First waiter becomes the head; its own link is cleared.
            head_we = 1'b1;
          end else begin
            // Append behind the old tail; own link is cleared next cycle.
            next_waddr = tail_rdata;
            next_wdata = thr_r;
          end
        end
      end
      csb_pkg::BK_LINK: next_we = 1'b1;
      csb_pkg::BK_HEAD: begin
        head_we    = 1'b1;
        head_wdata = next_rdata;
      end
      csb_pkg::BK_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csb_pkg::BK_IDLE;
      init_r      <= csb_pkg::InitCountReset;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        init_r    <= cfg_wdata;
        cnt_vld_r <= '0;
      end else if (cnt_we) begin
        cnt_vld_r[sem_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_pop) begin
      op_r   <= req.op;
      sem_r  <= s_w;
      thr_r  <= t_w;
      cvld_r <= cnt_vld_r[s_w];
    end
    if (state_r == csb_pkg::BK_EXEC) begin
      res_status_r <= status_c;
      res_woken_r  <= woken_c;
      res_count_r  <= c_new;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_woken_r  <= res_woken_r;
      out_count_r  <= res_count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_count_r, 4'(out_woken_r)};

endmodule

[sv/counting_semaphore_bank_unit.sv]
`timescale 1ns / 1ps
// Top level of the counting semaphore bank: front end, queue and back end.
// Depends on csb_pkg, csb_front, csb_back and csb_ram.

// A bank of NUM_SEMAPHORES counting semaphores, each with a FIFO of waiting
// threads kept as one next link per thread plus a head and tail per
// semaphore. A wait item takes a unit (granted, or blocked and queued); a
// signal item releases one and, when threads wait, wakes the oldest. Every
// item yields exactly one result item carrying the status, the woken thread
// and the new count. Ids wrap modulo the bank sizes. Counts saturate at 255
// and a wait at a full queue is refused; both report overflow. In the back
// end an item goes through table read, update and result load, plus a
// second link or head write when needed; this read-modify-write of the
// count, head, tail and link memories sets the rate. A two-entry queue
// behind the input lets new items in while a result waits to be taken.
// Writing cfg_wdata reloads every count with the new initial value and
// empties all queues; do so only while the block is idle.
module counting_semaphore_bank_unit #(
  parameter int unsigned NUM_SEMAPHORES = csb_pkg::DefaultNumSemaphores,
  parameter int unsigned NUM_THREADS    = csb_pkg::DefaultNumThreads
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: initial count.
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // Request stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] sem_id, [6:3] thread_id, [7] zero
  input  logic        in_tuser,   // [0] op (0 wait, 1 signal)
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] woken_thread, [12:4] count_after
  output logic [2:0]  out_tuser   // [2:0] status
);

  logic          req_valid;
  logic          req_pop;
  csb_pkg::req_t req;

  // Front end accepts and classifies items into a short queue.
  csb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .req_valid(req_valid),
    .req      (req),
    .req_pop  (req_pop)
  );

  // Back end performs the semaphore update and owns the result register.
  csb_back #(
    .NUM_SEMAPHORES(NUM_SEMAPHORES),
    .NUM_THREADS   (NUM_THREADS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

[dv/csb_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the counting semaphore bank: predicts one result item per
// accepted request item and compares it with the result stream. Depends on csb_pkg.
module csb_result_checker
  import csb_pkg::*;
#(
  parameter int unsigned NUM_SEMAPHORES = DefaultNumSemaphores,
  parameter int unsigned NUM_THREADS    = DefaultNumThreads
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [7:0]                cfg_wdata,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [7:0]                in_tdata,
  input  logic                      in_tuser,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [15:0]               out_tdata,
  input  logic [2:0]                out_tuser,
  output int                        mismatch_count,
  output int                        results_owed,
  // Per semaphore: a signal now would follow a link not written since the last reload.
  output logic [NUM_SEMAPHORES-1:0] wake_link_unset
);

  typedef struct packed {
    status_t                  status;
    logic [ThreadIdWidth-1:0] woken;
    logic signed [CountWidth-1:0] count;
  } sem_result_t;

  logic [InitWidth-1:0]     init_count;
  int                       count_tbl [NUM_SEMAPHORES];
  logic [ThreadIdWidth-1:0] head_tbl  [NUM_SEMAPHORES];
  logic [ThreadIdWidth-1:0] tail_tbl  [NUM_SEMAPHORES];
  logic [ThreadIdWidth-1:0] link_tbl  [NUM_THREADS];
  bit                       link_set  [NUM_THREADS];
  sem_result_t              owed_results [$];

  function automatic void reload_bank();
    for (int i = 0; i < NUM_SEMAPHORES; i++) begin
      count_tbl[i] = int'(init_count);
      head_tbl[i]  = '0;
      tail_tbl[i]  = '0;
    end
    for (int i = 0; i < NUM_THREADS; i++) begin
      link_tbl[i] = '0;
      link_set[i] = 1'b0;
    end
  endfunction

  // Applies one request to the bank and returns the result item it yields.
  function automatic sem_result_t run_request(input op_e_t op, input int unsigned s,
                                              input int unsigned t);
    sem_result_t r;
    int          c;
    int unsigned prev;
    c       = count_tbl[s];
    r.woken = '0;
    if (op == OP_WAIT) begin
      if (c <= -int'(NUM_THREADS)) begin
        r.status = ST_OVERFLOW;
      end else begin
        c = c - 1;
        if (c >= 0) begin
          r.status = ST_GRANTED;
        end else begin
          if (c == -1) begin
            head_tbl[s] = ThreadIdWidth'(t);
          end else begin
            prev           = tail_tbl[s] % NUM_THREADS;
            link_tbl[prev] = ThreadIdWidth'(t);
            link_set[prev] = 1'b1;
          end
          tail_tbl[s] = ThreadIdWidth'(t);
          link_tbl[t] = '0;
          link_set[t] = 1'b1;
          r.status    = ST_BLOCKED;
        end
      end
    end else if (c >= int'(CountMax)) begin
      c        = int'(CountMax);
      r.status = ST_OVERFLOW;
    end else if (c < 0) begin
      r.woken = ThreadIdWidth'(head_tbl[s] % NUM_THREADS);
      c       = c + 1;
      if (c < 0) begin
        head_tbl[s] = ThreadIdWidth'(link_tbl[r.woken] % NUM_THREADS);
      end
      r.status = ST_WOKE;
    end else begin
      c        = c + 1;
      r.status = ST_RELEASED;
    end
    count_tbl[s] = c;
    r.count      = CountWidth'(c);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    sem_result_t want;
    sem_result_t got;
    int unsigned s;
    int unsigned t;
    if (!rst_n) begin
      init_count     = InitCountReset;
      mismatch_count = 0;
      owed_results.delete();
      reload_bank();
    end else begin
      if (cfg_we) begin
        init_count = cfg_wdata;
        reload_bank();
      end
      if (in_tvalid && in_tready) begin
        s = in_tdata[SemIdWidth-1:0] % NUM_SEMAPHORES;
        t = in_tdata[SemIdWidth +: ThreadIdWidth] % NUM_THREADS;
        owed_results.push_back(run_request(op_e_t'(in_tuser), s, t));
      end
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser);
        got.woken  = out_tdata[3:0];
        got.count  = out_tdata[12:4];
        if (owed_results.size() == 0) begin
          $display("%0t: expected no result item, got status %0d woken %0d count %0d",
                   $time, got.status, got.woken, $signed(got.count));
          mismatch_count++;
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status || got.woken !== want.woken ||
              got.count !== want.count) begin
            $display({"%0t: expected status %0d woken %0d count %0d,",
                      " got status %0d woken %0d count %0d"},
                     $time, want.status, want.woken, $signed(want.count),
                     got.status, got.woken, $signed(got.count));
            mismatch_count++;
          end
        end
      end
    end
    results_owed = owed_results.size();
    for (int i = 0; i < NUM_SEMAPHORES; i++) begin
      wake_link_unset[i] = (count_tbl[i] < -1) && !link_set[head_tbl[i] % NUM_THREADS];
    end
  end

endmodule

[dv/counting_semaphore_bank_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the counting semaphore bank: clock, reset, stimulus, verdict.
// Depends on csb_pkg, counting_semaphore_bank_unit and csb_result_checker.
module counting_semaphore_bank_unit_tb;
  import csb_pkg::*;

  localparam int unsigned NumSems    = DefaultNumSemaphores;
  localparam int unsigned NumThreads = DefaultNumThreads;
  // The longest correct quiet stretch is the receiver hold-off below plus a few
  // long gaps; the watchdog limit sits well above that.
  localparam int          LongHold   = 300;
  localparam int          IdleLimit  = 3000;
  // Cycles left for the back end to settle before a register write.
  localparam int          Settle     = 8;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [7:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;

  int                  mismatch_count;
  int                  results_owed;
  logic [NumSems-1:0]  wake_link_unset;

  // When set, neither side idles: a stretch at full rate.
  bit no_idle     = 1'b0;
  // Bumped by the stimulus to ask the receiver for one long hold-off.
  int holds_asked = 0;
  int idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  counting_semaphore_bank_unit #(
    .NUM_SEMAPHORES(NumSems),
    .NUM_THREADS   (NumThreads)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  csb_result_checker #(
    .NUM_SEMAPHORES(NumSems),
    .NUM_THREADS   (NumThreads)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed),
    .wake_link_unset(wake_link_unset)
  );

  // Gap lengths shared by both sides: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) begin
      return 0;
    end
    if (roll < 88) begin
      return $urandom_range(1, 3);
    end
    if (roll < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Offers one request item and returns at the falling edge after it is taken,
  // possibly after an idle gap. With no gap, in_tvalid is left high so that the
  // next item follows back to back; the caller lowers it when a run ends.
  task automatic offer_request(input op_e_t op, input int s, input int t);
    int gap;
    // A signal would follow a link that a repeated wait reset and that was never
    // written since the last reload. That read is undefined in the block, so the
    // item turns into a wait, which is always well defined.
    if (op == OP_SIGNAL && wake_link_unset[s % NumSems]) begin
      op = OP_WAIT;
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, ThreadIdWidth'(t), SemIdWidth'(s)};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Holds the sender until every expected result item has come back.
  task automatic wait_drained();
    while (results_owed != 0) begin
      @(negedge clk);
    end
  endtask

  // Writes the initial count once the block is idle; this also reloads every
  // count and empties every queue.
  task automatic load_initial(input logic [7:0] value);
    wait_drained();
    repeat (Settle) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One random run of requests. wait_pct sets the share of waits, which drives
  // the counts down into long queues or up toward saturation. The semaphores
  // used are a window of span ids from a random base; a narrow window piles
  // requests onto few queues. At item pause_at the sender stops until every
  // result item has come back (a negative value means never).
  task automatic run_phase(input int n, input int wait_pct, input int span, input int pause_at);
    int    base;
    op_e_t op;
    base = $urandom_range(0, NumSems - 1);
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 99) < wait_pct) ? OP_WAIT : OP_SIGNAL;
      offer_request(op, (base + $urandom_range(0, span - 1)) % NumSems,
                    $urandom_range(0, NumThreads - 1));
      if (i == pause_at) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
        wait_drained();
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // Result side: random stalls, a full-rate mode, and one long hold-off on
  // request during which the sender keeps offering until the block backs up.
  initial begin : result_taker
    int stall;
    int holds_served;
    stall        = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_asked != holds_served) begin
        holds_served = holds_asked;
        out_tready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk);
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          stall--;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: any accepted item on either channel, or a register write, counts
  // as progress. A long quiet stretch means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("counting_semaphore_bank_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset count is one. A semaphore goes from granted to a queue of three
    // waiters, which then wake in the order they arrived, and back to free.
    offer_request(OP_WAIT,   0, 0);
    offer_request(OP_WAIT,   0, 15);
    offer_request(OP_WAIT,   0, 0);
    offer_request(OP_WAIT,   0, 7);
    offer_request(OP_SIGNAL, 0, 1);
    offer_request(OP_SIGNAL, 0, 2);
    offer_request(OP_SIGNAL, 0, 4);
    offer_request(OP_SIGNAL, 0, 8);
    // Highest semaphore: release with no waiter, then one thread waits twice in
    // the same queue so that its link gets rewritten.
    offer_request(OP_SIGNAL, 7, 15);
    offer_request(OP_WAIT,   7, 9);
    offer_request(OP_WAIT,   7, 9);
    offer_request(OP_WAIT,   7, 9);
    offer_request(OP_WAIT,   7, 9);
    offer_request(OP_SIGNAL, 7, 6);
    offer_request(OP_SIGNAL, 7, 6);
    offer_request(OP_SIGNAL, 7, 6);
    in_tvalid <= 1'b0;

    // Full count: a signal saturates and reports overflow.
    load_initial(8'd255);
    offer_request(OP_SIGNAL, 2, 0);
    offer_request(OP_WAIT,   2, 1);
    offer_request(OP_SIGNAL, 2, 14);
    offer_request(OP_SIGNAL, 6, 8);
    in_tvalid <= 1'b0;

    // Empty start with mostly waits on two semaphores fills queues up to the
    // thread limit, where further waits are refused.
    load_initial(8'd0);
    run_phase(126, 80, 2, -1);

    // Long receiver hold-off while requests keep coming.
    load_initial(8'd255);
    holds_asked++;
    run_phase(126, 25, NumSems, -1);

    // Full-rate stretch with no idling on either side.
    load_initial(8'd1);
    no_idle = 1'b1;
    run_phase(126, 50, NumSems, -1);
    no_idle = 1'b0;

    // Near saturation on two semaphores, with a full drain half way through.
    load_initial(8'd254);
    run_phase(126, 30, 2, 63);

    load_initial(8'd3);
    run_phase(126, 55, NumSems, -1);

    load_initial(8'($urandom_range(0, 255)));
    run_phase(126, 50, NumSems, -1);

    load_initial(8'd0);
    run_phase(126, 50, NumSems, -1);

    load_initial(8'd2);
    run_phase(126, 65, 4, -1);

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("counting_semaphore_bank_unit: match");
    end else begin
      $display("counting_semaphore_bank_unit: mismatch");
    end
    $finish;
  end

endmodule
